[rtl/blg_pkg.sv]
// Package for the battery level gauge: widths, register indexes, reset values and shared types.
package blg_pkg;

  // Field widths
  localparam int unsigned SAMPLE_W = 6;
  localparam int unsigned LEVEL_W  = 3;
  localparam int unsigned MV_W     = 16;
  localparam int unsigned GAIN_W   = 12;
  localparam int unsigned OHMS_W   = 16;

  // Arithmetic widths: scaled reading, product, gained reading, resistor sum, numerator, denominator, step count
  localparam int unsigned SCALED_W = 11;
  localparam int unsigned PROD_W   = 17;
  localparam int unsigned GAINED_W = SCALED_W + GAIN_W;
  localparam int unsigned RSUM_W   = OHMS_W + 1;
  localparam int unsigned NUM_W    = GAINED_W + RSUM_W;
  localparam int unsigned DEN_W    = 26;
  localparam int unsigned STEPS_W  = $clog2(NUM_W + 1);

  // Conversion constants
  localparam logic [SCALED_W-1:0] MV_SCALE   = 11'd2000;
  localparam logic [SAMPLE_W-1:0] ADC_FULL   = 6'h3f;
  localparam logic [9:0]          DEN_SCALE  = 10'd1000;
  localparam logic [MV_W-1:0]     MV_SAT     = 16'hffff;

  // APB port
  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 32;

  // Register indexes
  localparam logic [2:0] REG_GAIN = 3'd0;
  localparam logic [2:0] REG_RH   = 3'd1;
  localparam logic [2:0] REG_RL   = 3'd2;
  localparam logic [2:0] REG_TH1  = 3'd3;
  localparam logic [2:0] REG_TH2  = 3'd4;
  localparam logic [2:0] REG_TH3  = 3'd5;
  localparam logic [2:0] REG_TH4  = 3'd6;
  localparam logic [2:0] REG_TH5  = 3'd7;

  // Register reset values
  localparam logic [GAIN_W-1:0] GAIN_RST = 12'd1027;
  localparam logic [OHMS_W-1:0] RH_RST   = 16'd1;
  localparam logic [OHMS_W-1:0] RL_RST   = 16'd1;
  localparam logic [MV_W-1:0]   TH1_RST  = 16'd4074;
  localparam logic [MV_W-1:0]   TH2_RST  = 16'd4156;
  localparam logic [MV_W-1:0]   TH3_RST  = 16'd4318;
  localparam logic [MV_W-1:0]   TH4_RST  = 16'd4482;
  localparam logic [MV_W-1:0]   TH5_RST  = 16'd4644;

  // Level codes
  localparam logic [LEVEL_W-1:0] LVL_SHUTDOWN = 3'd0;
  localparam logic [LEVEL_W-1:0] LVL_ONE      = 3'd1;
  localparam logic [LEVEL_W-1:0] LVL_TWO      = 3'd2;
  localparam logic [LEVEL_W-1:0] LVL_THREE    = 3'd3;
  localparam logic [LEVEL_W-1:0] LVL_FOUR     = 3'd4;
  localparam logic [LEVEL_W-1:0] LVL_FULL     = 3'd5;

  // Configuration register file contents
  typedef struct packed {
    logic [GAIN_W-1:0] gain;
    logic [OHMS_W-1:0] r_high;
    logic [OHMS_W-1:0] r_low;
    logic [MV_W-1:0]   th1;
    logic [MV_W-1:0]   th2;
    logic [MV_W-1:0]   th3;
    logic [MV_W-1:0]   th4;
    logic [MV_W-1:0]   th5;
  } cfg_t;

  // Divider request
  typedef struct packed {
    logic               start;
    logic [STEPS_W-1:0] steps;
  } div_req_t;

endpackage

[rtl/blg_in_if.sv]
// Request channel carrying one ADC reading into the gauge.
interface blg_in_if import blg_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  logic                sample_ready;

  modport source (output valid, output sample, output sample_ready, input ready);
  modport sink   (input valid, input sample, input sample_ready, output ready);
endinterface

[rtl/blg_out_if.sv]
// Request channel carrying one gauge result out of the block.
interface blg_out_if import blg_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [LEVEL_W-1:0]  battery_level;
  logic [MV_W-1:0]     voltage_mv;
  logic [SAMPLE_W-1:0] window_average;

  modport source (output valid, output battery_level, output voltage_mv,
                  output window_average, input ready);
  modport sink   (input valid, input battery_level, input voltage_mv,
                  input window_average, output ready);
endinterface

[rtl/blg_regs.sv]
// APB configuration register file of the battery level gauge.
module blg_regs import blg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;

  // Write the addressed register in the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain   <= GAIN_RST;
      cfg_q.r_high <= RH_RST;
      cfg_q.r_low  <= RL_RST;
      cfg_q.th1    <= TH1_RST;
      cfg_q.th2    <= TH2_RST;
      cfg_q.th3    <= TH3_RST;
      cfg_q.th4    <= TH4_RST;
      cfg_q.th5    <= TH5_RST;
    end else if (wr_en) begin
      case (idx)
        REG_GAIN: cfg_q.gain   <= pwdata[GAIN_W-1:0];
        REG_RH:   cfg_q.r_high <= pwdata[OHMS_W-1:0];
        REG_RL:   cfg_q.r_low  <= pwdata[OHMS_W-1:0];
        REG_TH1:  cfg_q.th1    <= pwdata[MV_W-1:0];
        REG_TH2:  cfg_q.th2    <= pwdata[MV_W-1:0];
        REG_TH3:  cfg_q.th3    <= pwdata[MV_W-1:0];
        REG_TH4:  cfg_q.th4    <= pwdata[MV_W-1:0];
        REG_TH5:  cfg_q.th5    <= pwdata[MV_W-1:0];
        default:  ;
      endcase
    end
  end

  // Return the addressed register
  always_comb begin
    case (idx)
      REG_GAIN: prdata = PDATA_W'(cfg_q.gain);
      REG_RH:   prdata = PDATA_W'(cfg_q.r_high);
      REG_RL:   prdata = PDATA_W'(cfg_q.r_low);
      REG_TH1:  prdata = PDATA_W'(cfg_q.th1);
      REG_TH2:  prdata = PDATA_W'(cfg_q.th2);
      REG_TH3:  prdata = PDATA_W'(cfg_q.th3);
      REG_TH4:  prdata = PDATA_W'(cfg_q.th4);
      REG_TH5:  prdata = PDATA_W'(cfg_q.th5);
      default:  prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/blg_window.sv]
// Sliding window of readings with running sum and fill count.
module blg_window import blg_pkg::*; #(
  parameter int unsigned WINDOW = 6,
  parameter int unsigned CNT_W  = $clog2(WINDOW + 1),
  parameter int unsigned SUM_W  = SAMPLE_W + $clog2(WINDOW + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic [SAMPLE_W-1:0] reading_i,
  output logic [SUM_W-1:0]    sum_o,
  output logic [CNT_W-1:0]    held_o
);

  localparam logic [CNT_W-1:0] FULL = CNT_W'(WINDOW);

  logic [SAMPLE_W-1:0] win_q [WINDOW];
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [CNT_W-1:0]    held_q, held_d;

  // Shift the line down; the newest reading enters at the top
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      for (int i = 0; i + 1 < WINDOW; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[WINDOW-1] <= reading_i;
    end
  end

  // Grow while filling, then drop the oldest reading from the sum
  always_comb begin
    held_d = held_q;
    sum_d  = sum_q;
    if (held_q != FULL) begin
      held_d = held_q + 1'b1;
      sum_d  = sum_q + SUM_W'(reading_i);
    end else begin
      sum_d  = sum_q - SUM_W'(win_q[0]) + SUM_W'(reading_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      sum_q  <= '0;
    end else if (push_i) begin
      held_q <= held_d;
      sum_q  <= sum_d;
    end
  end

  assign sum_o  = sum_q;
  assign held_o = held_q;

endmodule

[rtl/blg_serial_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
module blg_serial_div import blg_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  div_req_t         req_i,
  input  logic [NUM_W-1:0] dividend_i,
  input  logic [DEN_W-1:0] divisor_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quotient_o
);

  logic               busy_q, done_q;
  logic [STEPS_W-1:0] cnt_q, steps_q;
  logic [NUM_W-1:0]   quo_q;
  logic [DEN_W-1:0]   rem_q, div_q;
  logic [DEN_W:0]     shifted;
  logic [DEN_W+1:0]   diff;
  logic               fits;

  // Bring in the next dividend bit and trial-subtract the divisor
  assign shifted = {rem_q, quo_q[NUM_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, div_q};
  assign fits    = !diff[DEN_W+1];

  // Hold the operands and advance one bit per cycle
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q   <= dividend_i;
      rem_q   <= '0;
      div_q   <= divisor_i;
      steps_q <= req_i.steps;
    end else if (busy_q) begin
      quo_q <= {quo_q[NUM_W-2:0], fits};
      rem_q <= fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == steps_q - 1'b1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

[rtl/battery_level_gauge_unit.sv]
// Top level of the battery level gauge: window averaging, millivolt conversion, level.
//
// Readings arrive on in_chan_i (sample, sample_ready); a clear sample_ready
// stands for a full-scale reading. Each accepted reading enters a window of
// the last WINDOW readings, and one result leaves on out_chan_o: the level
// 0..5, the battery voltage in millivolts (saturated) and the window mean.
// Registers are written through the APB port; pready is always high.
//
// One shared bit-serial divider does all the work in turn: the mean
// (SUM_W steps), the 2000/63 scaling (17 steps) and the divider ratio
// (40 steps), with two multiply steps between. The block takes one
// reading at a time. in_chan_i is ready again as soon as the result is in
// the output register, so the next reading is taken while the result
// waits; a stalled receiver holds that result and blocks only the
// hand-over of the following one.
// Reset empties the window, restores the register defaults and drops any
// result not yet taken.
module battery_level_gauge_unit import blg_pkg::*; #(
  parameter int unsigned WINDOW = 6
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  blg_in_if.sink             in_chan_i,
  blg_out_if.source          out_chan_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int unsigned CNT_W = $clog2(WINDOW + 1);
  localparam int unsigned SUM_W = SAMPLE_W + $clog2(WINDOW + 1);

  // Sequencer codes
  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_AVG_GO    = 4'd1;
  localparam logic [3:0] ST_AVG_RUN   = 4'd2;
  localparam logic [3:0] ST_SCL_GO    = 4'd3;
  localparam logic [3:0] ST_SCL_RUN   = 4'd4;
  localparam logic [3:0] ST_MUL_GAIN  = 4'd5;
  localparam logic [3:0] ST_MUL_RATIO = 4'd6;
  localparam logic [3:0] ST_VOLT_GO   = 4'd7;
  localparam logic [3:0] ST_VOLT_RUN  = 4'd8;
  localparam logic [3:0] ST_OUT       = 4'd9;

  cfg_t                cfg;
  logic [3:0]          state_q, state_d;
  logic                in_acc, out_acc, out_free;
  logic [SAMPLE_W-1:0] reading;
  logic [SUM_W-1:0]    win_sum;
  logic [CNT_W-1:0]    win_held;

  div_req_t            div_req;
  logic [NUM_W-1:0]    div_dividend;
  logic [DEN_W-1:0]    div_divisor;
  logic                div_done;
  logic [NUM_W-1:0]    div_quo;

  logic [SAMPLE_W-1:0] avg_q;
  logic [PROD_W-1:0]   prod;
  logic [SCALED_W-1:0] scaled_q;
  logic [GAINED_W-1:0] gained_q;
  logic [RSUM_W-1:0]   rsum;
  logic [NUM_W-1:0]    num_q;
  logic [DEN_W-1:0]    den_q;
  logic [MV_W-1:0]     mv_q, mv_d;
  logic [LEVEL_W-1:0]  level;

  logic                out_valid_q;
  logic [LEVEL_W-1:0]  out_level_q;
  logic [MV_W-1:0]     out_mv_q;
  logic [SAMPLE_W-1:0] out_avg_q;

  blg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Substitute full scale when the conversion has not finished
  assign reading   = in_chan_i.sample_ready ? in_chan_i.sample : ADC_FULL;
  assign in_chan_i.ready = (state_q == ST_IDLE);
  assign in_acc    = in_chan_i.valid && in_chan_i.ready;
  assign out_acc   = out_valid_q && out_chan_o.ready;
  assign out_free  = !out_valid_q || out_chan_o.ready;

  blg_window #(
    .WINDOW (WINDOW),
    .CNT_W  (CNT_W),
    .SUM_W  (SUM_W)
  ) u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (in_acc),
    .reading_i (reading),
    .sum_o     (win_sum),
    .held_o    (win_held)
  );

  // Select the divider operands, left-aligning each dividend
  assign prod = PROD_W'(avg_q) * PROD_W'(MV_SCALE);
  always_comb begin
    div_req.start = 1'b0;
    div_req.steps = STEPS_W'(NUM_W);
    div_dividend  = num_q;
    div_divisor   = den_q;
    case (state_q)
      ST_AVG_GO: begin
        div_req.start = 1'b1;
        div_req.steps = STEPS_W'(SUM_W);
        div_dividend  = {win_sum, {(NUM_W-SUM_W){1'b0}}};
        div_divisor   = DEN_W'(win_held);
      end
      ST_SCL_GO: begin
        div_req.start = 1'b1;
        div_req.steps = STEPS_W'(PROD_W);
        div_dividend  = {prod, {(NUM_W-PROD_W){1'b0}}};
        div_divisor   = DEN_W'(ADC_FULL);
      end
      ST_VOLT_GO: begin
        div_req.start = 1'b1;
      end
      default: ;
    endcase
  end

  blg_serial_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Saturate the voltage; a zero lower resistor reads as full scale
  assign rsum = {1'b0, cfg.r_high} + {1'b0, cfg.r_low};
  always_comb begin
    if ((den_q == '0) || (div_quo[NUM_W-1:MV_W] != '0)) begin
      mv_d = MV_SAT;
    end else begin
      mv_d = div_quo[MV_W-1:0];
    end
  end

  // Classify as a priority chain, first test that holds wins
  always_comb begin
    if (mv_q < cfg.th1) begin
      level = LVL_SHUTDOWN;
    end else if (mv_q <= cfg.th2) begin
      level = LVL_ONE;
    end else if (mv_q <= cfg.th3) begin
      level = LVL_TWO;
    end else if (mv_q <= cfg.th4) begin
      level = LVL_THREE;
    end else if (mv_q <= cfg.th5) begin
      level = LVL_FOUR;
    end else begin
      level = LVL_FULL;
    end
  end

  // Advance the sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:      if (in_acc) state_d = ST_AVG_GO;
      ST_AVG_GO:    state_d = ST_AVG_RUN;
      ST_AVG_RUN:   if (div_done) state_d = ST_SCL_GO;
      ST_SCL_GO:    state_d = ST_SCL_RUN;
      ST_SCL_RUN:   if (div_done) state_d = ST_MUL_GAIN;
      ST_MUL_GAIN:  state_d = ST_MUL_RATIO;
      ST_MUL_RATIO: state_d = ST_VOLT_GO;
      ST_VOLT_GO:   state_d = ST_VOLT_RUN;
      ST_VOLT_RUN:  if (div_done) state_d = ST_OUT;
      ST_OUT:       if (out_free) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Capture intermediate results as each step finishes
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_AVG_RUN) && div_done) begin
      avg_q <= div_quo[SAMPLE_W-1:0];
    end
    if ((state_q == ST_SCL_RUN) && div_done) begin
      scaled_q <= div_quo[SCALED_W-1:0];
    end
    if (state_q == ST_MUL_GAIN) begin
      gained_q <= scaled_q * cfg.gain;
    end
    if (state_q == ST_MUL_RATIO) begin
      num_q <= NUM_W'(gained_q) * NUM_W'(rsum);
      den_q <= DEN_W'(cfg.r_low) * DEN_W'(DEN_SCALE);
    end
    if ((state_q == ST_VOLT_RUN) && div_done) begin
      mv_q <= mv_d;
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_OUT) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_acc) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_OUT) && out_free) begin
      out_level_q <= level;
      out_mv_q    <= mv_q;
      out_avg_q   <= avg_q;
    end
  end

  assign out_chan_o.valid          = out_valid_q;
  assign out_chan_o.battery_level  = out_level_q;
  assign out_chan_o.voltage_mv     = out_mv_q;
  assign out_chan_o.window_average = out_avg_q;

endmodule
